// ----- sv/cqd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the circular queue with dump.
// Used by cqd_ctrl, cqd_datapath and circular_queue_with_dump; no dependencies.
package cqd_pkg;

  localparam int DefMaxDepth = 16;
  localparam int CapW        = 5;
  localparam int ModeW       = 2;
  localparam int StatusW     = 2;
  localparam int DataW       = 32;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_DELETE  = 2'd1,
    MODE_DISPLAY = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ_READ,
    S_DISP_READ,
    S_RESP,
    S_DISP_RESP
  } state_e;

  typedef struct packed {
    logic insert;
    logic overflow;
    logic empty_resp;
    logic dequeue;
    logic disp_start;
    logic walk;
    logic capture;
    logic capture_last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_last;
  } stat_t;

endpackage

// ----- sv/cqd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine for the circular queue with dump.
// Depends on cqd_pkg for the state, mode, command and status types.
module cqd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [cqd_pkg::ModeW-1:0] mode_i,
  input  logic                      out_ready_i,
  input  cqd_pkg::stat_t            stat_i,
  output cqd_pkg::cmd_t             cmd_o,
  output logic                      in_ready_o,
  output logic                      out_valid_o
);
  import cqd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_e'(mode_i))
            MODE_INSERT:  state_d = S_RESP;
            MODE_DELETE:  state_d = stat_i.empty ? S_RESP : S_DEQ_READ;
            MODE_DISPLAY: state_d = stat_i.empty ? S_RESP : S_DISP_READ;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_DEQ_READ:  state_d = S_RESP;
      S_DISP_READ: state_d = S_DISP_RESP;
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_DISP_RESP: begin
        if (out_ready_i) begin
          state_d = stat_i.walk_last ? S_IDLE : S_DISP_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mode_e'(mode_i))
            MODE_INSERT: begin
              cmd_o.overflow = stat_i.full;
              cmd_o.insert   = !stat_i.full;
            end
            MODE_DELETE: begin
              cmd_o.empty_resp = stat_i.empty;
              cmd_o.dequeue    = !stat_i.empty;
            end
            MODE_DISPLAY: begin
              cmd_o.empty_resp = stat_i.empty;
              cmd_o.disp_start = !stat_i.empty;
            end
            default: ;
          endcase
        end
      end
      S_DEQ_READ: begin
        cmd_o.capture      = 1'b1;
        cmd_o.capture_last = 1'b1;
      end
      S_DISP_READ: begin
        cmd_o.capture      = 1'b1;
        cmd_o.capture_last = stat_i.walk_last;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      S_DISP_RESP: begin
        out_valid_o = 1'b1;
        cmd_o.walk  = out_ready_i && !stat_i.walk_last;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/cqd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the circular queue with dump: slot memory, head, count, capacity,
// display walk counter and result registers. Depends on cqd_pkg.
module cqd_datapath #(
  parameter int MaxDepth = cqd_pkg::DefMaxDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cqd_pkg::CapW-1:0]         cfg_wdata_i,
  input  logic signed [cqd_pkg::DataW-1:0] item_value_i,
  input  cqd_pkg::cmd_t                    cmd_i,
  output cqd_pkg::stat_t                   stat_o,
  output logic [cqd_pkg::StatusW-1:0]      status_o,
  output logic signed [cqd_pkg::DataW-1:0] data_value_o,
  output logic                             last_o
);
  import cqd_pkg::*;

  localparam int IdxW = $clog2(MaxDepth);
  localparam int CntW = $clog2(MaxDepth + 1);
  localparam int SumW = CntW + 1;
  localparam int ExtW = (CntW > CapW) ? CntW : CapW;

  function automatic logic [IdxW-1:0] wrap(input logic [IdxW-1:0] base,
                                          input logic [CntW-1:0] off,
                                          input logic [CntW-1:0] cap);
    logic [SumW-1:0] s;
    s = SumW'(base) + SumW'(off);
    if (s >= SumW'(cap)) begin
      s = s - SumW'(cap);
    end
    return s[IdxW-1:0];
  endfunction

  logic signed [DataW-1:0] mem [MaxDepth];
  logic signed [DataW-1:0] rd_q;

  logic [CapW-1:0] cap_q;
  logic [IdxW-1:0] head_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] k_q;

  status_e                 status_q;
  logic signed [DataW-1:0] data_q;
  logic                    last_q;

  logic [ExtW-1:0] cap_ext;
  logic [ExtW-1:0] cap_clamp;
  logic [CntW-1:0] eff_cap;
  logic [CntW-1:0] k_next;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] head_deq;
  logic            rd_en;

  assign cap_ext   = ExtW'(cap_q);
  assign cap_clamp = (cap_q == '0) ? ExtW'(1) :
                     (cap_ext > ExtW'(MaxDepth)) ? ExtW'(MaxDepth) : cap_ext;
  assign eff_cap   = cap_clamp[CntW-1:0];

  assign k_next   = k_q + CntW'(1);
  assign rd_addr  = wrap(head_q, cmd_i.walk ? k_next : '0, eff_cap);
  assign wr_addr  = wrap(head_q, count_q, eff_cap);
  assign head_deq = (count_q == CntW'(1)) ? '0 : wrap(head_q, CntW'(1), eff_cap);
  assign rd_en    = cmd_i.dequeue || cmd_i.disp_start || cmd_i.walk;

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      mem[wr_addr] <= item_value_i;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      head_q  <= '0;
      count_q <= '0;
      k_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        head_q  <= '0;
        count_q <= '0;
      end else if (cmd_i.insert) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.dequeue) begin
        count_q <= count_q - CntW'(1);
        head_q  <= head_deq;
      end
      if (cmd_i.disp_start) begin
        k_q <= '0;
      end else if (cmd_i.walk) begin
        k_q <= k_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      status_q <= ST_OK;
      data_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.overflow) begin
      status_q <= ST_OVERFLOW;
      data_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.empty_resp) begin
      status_q <= ST_EMPTY;
      data_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.capture) begin
      status_q <= ST_OK;
      data_q   <= rd_q;
      last_q   <= cmd_i.capture_last;
    end
  end

  assign stat_o.full      = count_q >= eff_cap;
  assign stat_o.empty     = count_q == '0;
  assign stat_o.walk_last = k_next == count_q;

  assign status_o     = status_q;
  assign data_value_o = data_q;
  assign last_o       = last_q;

endmodule

// ----- sv/circular_queue_with_dump.sv -----
`timescale 1ns / 1ps
// Circular queue of signed 32-bit values with a run-time capacity and a dump.
// The input channel carries a mode and a value, the output channel a status, a
// value and a last flag; every input transaction other than the unused mode gives
// at least one output transaction, and display gives one per stored value, oldest
// first. The unused mode is accepted and gives no output transaction.
// One input transaction is in flight at a time: the input is ready only while
// the block is idle. An insert or an overflow, underflow or empty answer is
// shown in the cycle after acceptance. A delete and each displayed value pass
// through the registered read port of the slot memory and then the result
// register, after acceptance or after the previous display value was taken.
// The result stays in its register while the receiver stalls.
// Reset empties the queue and sets the capacity to 16; the slot memory is
// not cleared. Writing the capacity empties the queue and should be done while
// the block is idle. Capacity 0 acts as 1 and values above MaxDepth as MaxDepth.
// Depends on cqd_pkg, cqd_ctrl and cqd_datapath.
module circular_queue_with_dump #(
  parameter int MaxDepth = cqd_pkg::DefMaxDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cqd_pkg::CapW-1:0]         cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cqd_pkg::ModeW-1:0]        mode_i,
  input  logic signed [cqd_pkg::DataW-1:0] item_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cqd_pkg::StatusW-1:0]      status_o,
  output logic signed [cqd_pkg::DataW-1:0] data_value_o,
  output logic                             last_o
);
  import cqd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  cqd_datapath #(
    .MaxDepth (MaxDepth)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_value_i (item_value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .data_value_o (data_value_o),
    .last_o       (last_o)
  );

`ifndef NO_ASSERTIONS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input ready while a result is pending.");

  a_insert_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == MODE_INSERT) |=> (out_valid_o && last_o))
    else $error("Insert did not answer in the next cycle.");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (last_o && data_value_o == '0))
    else $error("Error result is not a final, zero-valued transaction.");
`endif

endmodule

// ----- sim/circular_queue_with_dump_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for circular_queue_with_dump: a queued driver, a monitor and a
// mirror of the queue that predicts every result. Depends on cqd_pkg and the block's RTL.
module circular_queue_with_dump_tb;
  import cqd_pkg::*;

  localparam int MaxDepth     = DefMaxDepth;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 40;
  localparam int HoldCycles   = 80;
  localparam int StuckLimit   = 2000;
  localparam int PrintLimit   = 30;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef enum int {
    STEP_OP,
    STEP_CFG,
    STEP_PACE,
    STEP_HOLD,
    STEP_SYNC
  } step_kind_e;

  typedef struct {
    step_kind_e      kind;
    int              arg;
    int              arg2;
    logic [DataW-1:0] value;
  } plan_step_t;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] data;
    logic             last;
  } reply_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [CapW-1:0]         cfg_wdata_i  = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [ModeW-1:0]        mode_i       = '0;
  logic signed [DataW-1:0] item_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [StatusW-1:0]      status_o;
  logic signed [DataW-1:0] data_value_o;
  logic                    last_o;

  plan_step_t op_backlog[$];
  reply_t     pending_replies[$];

  logic [DataW-1:0] mirror_slots[MaxDepth];
  int unsigned      mirror_head  = 0;
  int unsigned      mirror_count = 0;
  logic [CapW-1:0]  mirror_cap   = CapReset;

  int unsigned gen_cap   = MaxDepth;
  int unsigned gen_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_len      = 0;
  int hold_left     = 0;

  logic       drained = 1'b1;
  logic       drv_valid;
  logic       drv_we;
  logic       drv_took;
  int         drv_settle = 0;
  plan_step_t drv_step;
  reply_t     mon_want;

  int ops_accepted   = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;
  int mismatches     = 0;
  int overflows      = 0;
  int empty_answers  = 0;
  int ignored_ops    = 0;
  int longest_dump   = 0;
  int last_progress  = 0;
  int stuck          = 0;

  circular_queue_with_dump DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .item_value_i(item_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_value_o(data_value_o),
    .last_o      (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned eff_cap_of(input logic [CapW-1:0] c);
    if (c == 0) return 1;
    if (c > MaxDepth) return MaxDepth;
    return c;
  endfunction

  function automatic int unsigned slot_at(input int unsigned k, input int unsigned cap);
    int unsigned s;
    s = mirror_head + k;
    if (s >= cap) s -= cap;
    if (s >= MaxDepth) s = 0;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] want,
                                 input logic [DataW-1:0] got);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("mismatch at %0t ns: %s, wanted %0h, got %0h", $time, what, want, got);
  endtask

  task automatic apply_queue_op(input logic [ModeW-1:0] mode, input logic [DataW-1:0] val);
    int unsigned cap;
    int unsigned k;
    logic [DataW-1:0] d;
    cap = eff_cap_of(mirror_cap);
    case (mode)
      MODE_INSERT: begin
        if (mirror_count >= cap) begin
          pending_replies.push_back('{ST_OVERFLOW, '0, 1'b1});
          overflows++;
        end else begin
          mirror_slots[slot_at(mirror_count, cap)] = val;
          mirror_count++;
          pending_replies.push_back('{ST_OK, '0, 1'b1});
        end
      end
      MODE_DELETE: begin
        if (mirror_count == 0) begin
          pending_replies.push_back('{ST_EMPTY, '0, 1'b1});
          empty_answers++;
        end else begin
          d = mirror_slots[slot_at(0, cap)];
          mirror_count--;
          mirror_head = (mirror_count == 0) ? 0 : slot_at(1, cap);
          pending_replies.push_back('{ST_OK, d, 1'b1});
        end
      end
      MODE_DISPLAY: begin
        if (mirror_count == 0) begin
          pending_replies.push_back('{ST_EMPTY, '0, 1'b1});
          empty_answers++;
        end else begin
          for (k = 0; k < mirror_count && k < MaxDepth; k++)
            pending_replies.push_back('{ST_OK, mirror_slots[slot_at(k, cap)],
                                        (k + 1 == mirror_count)});
          if (mirror_count > longest_dump) longest_dump = mirror_count;
        end
      end
      default: begin
        ignored_ops++;
      end
    endcase
  endtask

  task automatic plan(input step_kind_e kind, input int arg = 0,
                      input logic [DataW-1:0] val = '0, input int arg2 = 0);
    op_backlog.push_back('{kind, arg, arg2, val});
    if (kind == STEP_CFG) begin
      gen_cap   = eff_cap_of(CapW'(arg));
      gen_count = 0;
    end else if (kind == STEP_OP && arg == MODE_INSERT && gen_count < gen_cap) begin
      gen_count++;
    end else if (kind == STEP_OP && arg == MODE_DELETE && gen_count > 0) begin
      gen_count--;
    end
  endtask

  function automatic logic [DataW-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 32'h7FFF_FFFF;
    if (r < 16) return 32'h8000_0000;
    if (r < 20) return '0;
    if (r < 24) return '1;
    return $urandom();
  endfunction

  task automatic plan_fill_and_dump(output int added);
    int n;
    n = gen_cap - gen_count + 1;
    repeat (n) plan(STEP_OP, MODE_INSERT, pick_value());
    plan(STEP_OP, MODE_DISPLAY, $urandom());
    added = n + 1;
  endtask

  task automatic plan_random(input int n);
    int done;
    int r;
    int added;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 40) begin
        plan(STEP_OP, MODE_INSERT, pick_value());
        done++;
      end else if (r < 68) begin
        plan(STEP_OP, MODE_DELETE, $urandom());
        done++;
      end else if (r < 82) begin
        plan(STEP_OP, MODE_DISPLAY, $urandom());
        done++;
      end else if (r < 87) begin
        plan(STEP_OP, ModeUnused, $urandom());
        done++;
      end else begin
        plan_fill_and_dump(added);
        done += added;
      end
    end
  endtask

  // Driver: one transaction is offered at a time; control steps run only while no item
  // is being offered, and a capacity write waits until every result has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      mode_i       <= '0;
      item_value_i <= '0;
      cfg_we_i     <= 1'b0;
      cfg_wdata_i  <= '0;
    end else begin
      drv_valid = in_valid_i;
      drv_we    = 1'b0;
      drv_took  = 1'b0;
      if (in_valid_i && in_ready_o) begin
        apply_queue_op(mode_i, item_value_i);
        ops_accepted++;
        drv_valid = 1'b0;
        drv_took  = 1'b1;
      end
      if (!drv_valid && op_backlog.size() != 0) begin
        drv_step = op_backlog[0];
        case (drv_step.kind)
          STEP_OP: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              drv_valid = 1'b1;
              mode_i       <= ModeW'(drv_step.arg);
              item_value_i <= drv_step.value;
              void'(op_backlog.pop_front());
            end
          end
          STEP_PACE: begin
            send_idle_pct <= drv_step.arg;
            recv_idle_pct <= drv_step.arg2;
            void'(op_backlog.pop_front());
          end
          STEP_HOLD: begin
            hold_len <= drv_step.arg;
            hold_seq <= hold_seq + 1;
            void'(op_backlog.pop_front());
          end
          STEP_SYNC: begin
            if (drained && !drv_took) void'(op_backlog.pop_front());
          end
          STEP_CFG: begin
            if (!drained || drv_took) begin
              drv_settle = 0;
            end else if (drv_settle < SettleCycles) begin
              drv_settle++;
            end else begin
              drv_settle = 0;
              drv_we = 1'b1;
              cfg_wdata_i <= CapW'(drv_step.arg);
              mirror_cap   = CapW'(drv_step.arg);
              mirror_head  = 0;
              mirror_count = 0;
              cfg_writes++;
              void'(op_backlog.pop_front());
            end
          end
          default: begin
            void'(op_backlog.pop_front());
          end
        endcase
      end
      in_valid_i <= drv_valid;
      cfg_we_i   <= drv_we;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_replies.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, data_value_o);
        end else begin
          mon_want = pending_replies.pop_front();
          if (status_o !== mon_want.status)
            report_mismatch("status", mon_want.status, status_o);
          if (data_value_o !== mon_want.data)
            report_mismatch("data_value", mon_want.data, data_value_o);
          if (last_o !== mon_want.last)
            report_mismatch("last", mon_want.last, last_o);
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(negedge clk_i) begin
    drained = (pending_replies.size() == 0);
    if (ops_accepted + results_seen + cfg_writes != last_progress) begin
      last_progress = ops_accepted + results_seen + cfg_writes;
      stuck = 0;
    end else if (rst_ni) begin
      stuck++;
    end
    if (stuck == StuckLimit) begin
      $display("timeout: no transaction for %0d cycles", StuckLimit);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int added;

    plan(STEP_PACE, 36, '0, 68);
    plan(STEP_OP, MODE_DISPLAY, $urandom());
    plan(STEP_OP, MODE_DELETE, $urandom());
    plan(STEP_OP, ModeUnused, 32'hFFFF_FFFF);
    plan(STEP_OP, MODE_INSERT, 32'h7FFF_FFFF);
    plan(STEP_OP, MODE_INSERT, 32'h8000_0000);
    plan(STEP_OP, MODE_INSERT, 32'h0000_0000);
    plan(STEP_OP, MODE_INSERT, 32'hFFFF_FFFF);
    plan(STEP_OP, MODE_DISPLAY, $urandom());
    plan(STEP_OP, MODE_DELETE, $urandom());
    plan(STEP_OP, MODE_DELETE, $urandom());
    plan(STEP_CFG, 1);
    plan(STEP_OP, MODE_INSERT, 32'hA5A5_A5A5);
    plan(STEP_OP, MODE_INSERT, 32'h5A5A_5A5A);
    plan(STEP_OP, MODE_DISPLAY, $urandom());
    plan(STEP_OP, MODE_DELETE, $urandom());
    plan(STEP_OP, MODE_DELETE, $urandom());
    plan(STEP_OP, MODE_DISPLAY, $urandom());
    plan(STEP_CFG, 0);
    plan(STEP_OP, MODE_INSERT, 32'h1234_5678);
    plan(STEP_OP, MODE_INSERT, 32'h8765_4321);
    plan(STEP_OP, MODE_DELETE, $urandom());

    plan(STEP_CFG, 16);
    plan_fill_and_dump(added);
    plan_random(10);
    plan(STEP_SYNC);
    plan_random(12);

    plan(STEP_PACE, 68, '0, 36);
    plan(STEP_CFG, $urandom_range(2, 15));
    plan_random(13);

    plan(STEP_PACE, 0, '0, 0);
    plan(STEP_CFG, 31);
    plan_random(8);
    plan(STEP_HOLD, HoldCycles);
    plan_random(30);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    do @(negedge clk_i);
    while (op_backlog.size() != 0 || in_valid_i || pending_replies.size() != 0);
    repeat (TailCycles) @(negedge clk_i);
    if (pending_replies.size() != 0)
      report_mismatch("results never delivered", pending_replies.size(), '0);

    $display("Covered %0d input transactions, %0d results, %0d capacity writes.",
             ops_accepted, results_seen, cfg_writes);
    $display("Overflows %0d, underflow or empty answers %0d, ignored modes %0d, longest dump %0d.",
             overflows, empty_answers, ignored_ops, longest_dump);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/cqd_pkg.sv
sv/cqd_ctrl.sv
sv/cqd_datapath.sv
sv/circular_queue_with_dump.sv
sim/circular_queue_with_dump_tb.sv
